// ===== rtl/core/hcb_pkg.sv =====
// shared types and constants for the huffman code builder
`default_nettype none
package hcb_pkg;
    localparam int MaxSymbols = 32;
    localparam int NodeCount  = 2 * MaxSymbols - 1;
    localparam int NodeW      = 6;
    localparam int LinkW      = 7;
    localparam int WeightW    = 20;

    typedef logic [NodeW-1:0] t_node;
    typedef logic [LinkW-1:0] t_link;

    // parent link value for a node that has no parent yet
    localparam t_link NodeNone = t_link'(127);

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLEAR, ST_SCAN, ST_MERGE, ST_MERGE_HI, ST_WALK_INIT, ST_WALK, ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear_start;
        logic clear_step;
        logic scan_start;
        logic scan_step;
        logic merge_lo;
        logic merge_hi;
        logic walk_init;
        logic walk_step;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic build_done;
        logic walk_done;
        logic sym_done;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/hcb_datapath.sv =====
// node store, minimum scan, merge and code walk
`default_nettype none
module hcb_datapath import hcb_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic [14:0]  i_weight,
    input  wire logic [5:0]   i_load_idx,
    input  wire logic [5:0]   i_n,
    input  wire t_cmd         i_cmd,
    output t_status           o_status,
    output logic [4:0]        o_symbol,
    output logic [30:0]       o_code_bits,
    output logic [4:0]        o_code_length,
    output logic              o_last
);
    logic [WeightW-1:0] r_wmem [NodeCount];
    t_link r_pmem [NodeCount];
    t_node r_lmem [NodeCount];
    logic [WeightW-1:0] r_wq;
    t_link r_pq;
    t_node r_lq;
    t_node rd_addr;
    logic  w_we, p_we;
    t_node w_addr, p_addr;
    logic [WeightW-1:0] w_data;
    t_link p_data;
    t_node r_k, r_i, r_lo, r_hi, r_sym, r_c, r_ch, r_cmp_k;
    logic  r_issue, r_cmp_v, r_have_ch;
    logic  r_have1, r_have2;
    logic [WeightW-1:0] r_min1, r_min2;
    logic [30:0] r_code;
    logic [4:0]  depth_sat;
    logic [5:0]  r_depth_full;
    t_node n_k;

    assign n_k = r_k + t_node'(1);

    // one write and one registered read per memory and cycle
    always_comb begin
        w_we   = i_load || i_cmd.merge_lo;
        w_addr = i_cmd.merge_lo ? r_i : i_load_idx[NodeW-1:0];
        w_data = i_cmd.merge_lo ? WeightW'(r_min1 + r_min2) : WeightW'(i_weight);
        p_we   = i_cmd.clear_step || i_cmd.merge_lo || i_cmd.merge_hi;
        p_addr = r_k;
        p_data = NodeNone;
        if (i_cmd.merge_lo) begin
            p_addr = r_lo;
            p_data = {1'b0, r_i};
        end else if (i_cmd.merge_hi) begin
            p_addr = r_hi;
            p_data = {1'b0, r_i};
        end
        rd_addr = r_k;
        if (i_cmd.walk_init) rd_addr = r_sym;
        else if (i_cmd.walk_step && r_pq != NodeNone) rd_addr = r_pq[NodeW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[w_addr] <= w_data;
        r_wq <= r_wmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) r_pmem[p_addr] <= p_data;
        r_pq <= r_pmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge_lo) r_lmem[r_i] <= r_lo;
        r_lq <= r_lmem[rd_addr];
    end

    // scan issues one address a cycle, the compare follows in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_cmp_v <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issue <= 1'b1;
            r_cmp_v <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_issue <= r_issue && (n_k != r_i);
            r_cmp_v <= r_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_start || i_cmd.scan_start) r_k <= '0;
        else if (i_cmd.clear_step || (i_cmd.scan_step && r_issue)) r_k <= n_k;
        r_cmp_k <= r_k;
        if (i_cmd.clear_start) r_i <= i_n[NodeW-1:0];
        else if (i_cmd.merge_hi) r_i <= r_i + t_node'(1);
        if (i_cmd.scan_start) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else if (i_cmd.scan_step && r_cmp_v && r_pq == NodeNone) begin
            if (!r_have1 || r_wq < r_min1) begin
                if (r_have1) begin
                    r_min2 <= r_min1;
                    r_hi <= r_lo;
                    r_have2 <= 1'b1;
                end
                r_min1 <= r_wq;
                r_lo <= r_cmp_k;
                r_have1 <= 1'b1;
            end else if (!r_have2 || r_wq < r_min2) begin
                r_min2 <= r_wq;
                r_hi <= r_cmp_k;
                r_have2 <= 1'b1;
            end
        end
        if (i_cmd.walk_init) begin
            r_c <= r_sym;
            r_have_ch <= 1'b0;
            r_code <= '0;
            r_depth_full <= '0;
        end else if (i_cmd.walk_step) begin
            // read data belongs to r_c: its left child decides the bit of the edge below
            if (r_have_ch) begin
                if (r_depth_full < 6'd31)
                    r_code[r_depth_full[4:0]] <= (r_lq != r_ch);
                r_depth_full <= r_depth_full + 6'd1;
            end
            if (r_pq != NodeNone) begin
                r_ch <= r_c;
                r_c <= r_pq[NodeW-1:0];
                r_have_ch <= 1'b1;
            end
        end
        if (i_cmd.clear_start) r_sym <= '0;
        else if (i_cmd.emit_load) r_sym <= r_sym + t_node'(1);
    end

    assign depth_sat = (r_depth_full > 6'd31) ? 5'd31 : r_depth_full[4:0];
    assign o_status.clear_done = (r_k == t_node'(NodeCount - 1));
    assign o_status.scan_done  = r_cmp_v && !r_issue;
    assign o_status.build_done = ({1'b0, r_i} == {i_n, 1'b0} - 7'd2);
    assign o_status.walk_done  = (r_pq == NodeNone);
    assign o_status.sym_done   = ({1'b0, r_sym} + 7'd1 == {1'b0, i_n});
    assign o_symbol      = r_sym[4:0];
    assign o_code_bits   = r_code;
    assign o_code_length = depth_sat;
    assign o_last        = o_status.sym_done;
endmodule
`default_nettype wire

// ===== rtl/core/hcb_ctrl.sv =====
// sequencer for load, build and code output
`default_nettype none
module hcb_ctrl import hcb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_last_load,
    input  wire logic i_load,
    input  wire logic i_out_ready,
    input  wire t_status i_status,
    output t_cmd      o_cmd,
    output logic      o_busy,
    output logic      o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_out_valid = 1'b0;
        o_busy = (r_state != ST_LOAD);
        case (r_state)
            ST_LOAD: begin
                if (i_load && i_last_load) begin
                    o_cmd.clear_start = 1'b1;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = ST_MERGE;
            end
            ST_MERGE: begin
                o_cmd.merge_lo = 1'b1;
                n_state = ST_MERGE_HI;
            end
            ST_MERGE_HI: begin
                o_cmd.merge_hi = 1'b1;
                if (i_status.build_done) begin
                    n_state = ST_WALK_INIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = i_status.sym_done ? ST_LOAD : ST_WALK_INIT;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

`ifndef SYNTHESIS
    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == ST_EMIT) else $error("valid outside emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("beat dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !(o_cmd.clear_start)) else $error("restart while busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/huffman_code_builder_unit.sv =====
// huffman code builder top level
// after the last weight: a clear of all parent links, then for each merge i = N..2N-2 a scan
// of the root nodes below i, then a code walk for each symbol from its leaf up to the root
// throughput: one weight per cycle while loading; each code is held until i_ready
// no new weight is taken while the tree is built or codes are emitted
// synchronous active-low reset: symbol_count 32, load count 0, idle in load state
`default_nettype none
module huffman_code_builder_unit import hcb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [14:0] i_weight,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_symbol,
    output logic [30:0]      o_code_bits,
    output logic [4:0]       o_code_length,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_data
);
    logic [5:0] r_count, r_load, n_eff;
    logic busy, load, last_load;
    t_cmd cmd;
    t_status status;

    assign n_eff = (r_count < 6'd2) ? 6'd2 :
                   (r_count > 6'(MaxSymbols)) ? 6'(MaxSymbols) : r_count;
    assign o_ready = !busy;
    assign load = i_valid && o_ready;
    assign last_load = (r_load + 6'd1 == n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 6'd32;
            r_load <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
            r_load <= '0;
        end else if (load) begin
            r_load <= last_load ? 6'd0 : r_load + 6'd1;
        end
    end

    hcb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_last_load(last_load), .i_load(load),
        .i_out_ready(i_ready), .i_status(status), .o_cmd(cmd),
        .o_busy(busy), .o_out_valid(o_valid)
    );

    hcb_datapath u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_weight, .i_load_idx(r_load),
        .i_n(n_eff), .i_cmd(cmd), .o_status(status), .o_symbol,
        .o_code_bits, .o_code_length, .o_last
    );
endmodule
`default_nettype wire
